>>> hdl/pvr_pkg.sv
// Package for the packet verify and reassemble block: sizes, payload types and helpers.
package pvr_pkg;

  localparam int PAYLOAD_WORDS = 1024;
  localparam int ARRAY_WORDS   = 4096;

  localparam int PB_AW = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int AR_AW = (ARRAY_WORDS > 1) ? $clog2(ARRAY_WORDS) : 1;
  localparam int NW_W  = $clog2(PAYLOAD_WORDS + 1);
  localparam int IDX_W = 14;

  localparam logic [22:0] CSUM_MOD     = 23'h7FFFFF;
  localparam logic [13:0] HEADER_BYTES = 14'd16;
  localparam logic [13:0] POS_MAX      = 14'd16383;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_BAD = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    logic        last;
    logic [11:0] read_index;
  } pvr_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  packet_status;
    logic [22:0] computed_checksum;
    logic [22:0] received_checksum;
    logic [10:0] words_written;
    logic [31:0] total_count;
    logic signed [31:0] read_data;
  } pvr_out_t;

  typedef struct packed {
    logic              start;
    logic              ack;
    logic [NW_W-1:0]   nwords;
    logic [11:0]       base;
    logic [12:0]       limit;
  } pvr_copy_req_t;

  typedef struct packed {
    logic        done;
    logic [10:0] wrote;
  } pvr_copy_sts_t;

  function automatic logic [31:0] abs_wrap(input logic [31:0] w);
    abs_wrap = w[31] ? (32'd0 - w) : w;
  endfunction

endpackage

>>> hdl/pvr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pvr_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/pvr_copy.sv
// Copy sequencer that moves buffered payload words into the array store.
module pvr_copy (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pvr_pkg::pvr_copy_req_t        req,
  output pvr_pkg::pvr_copy_sts_t        sts,
  output logic                          buf_re,
  output logic [pvr_pkg::PB_AW-1:0]     buf_raddr,
  input  logic [31:0]                   buf_rdata,
  output logic                          arr_we,
  output logic [pvr_pkg::AR_AW-1:0]     arr_waddr,
  output logic [31:0]                   arr_wdata
);

  logic                        busy_r, busy_nxt;
  logic                        rd_act_r, rd_act_nxt;
  logic [pvr_pkg::NW_W-1:0]    k_r, k_nxt;
  logic                        wr_v_r, wr_v_nxt;
  logic [pvr_pkg::IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [10:0]                 wrote_r, wrote_nxt;
  logic                        in_range;

  assign in_range  = wr_idx_r < {1'b0, req.limit};
  assign buf_re    = rd_act_r;
  assign buf_raddr = k_r[pvr_pkg::PB_AW-1:0];
  assign arr_we    = wr_v_r && in_range;
  assign arr_waddr = wr_idx_r[pvr_pkg::AR_AW-1:0];
  assign arr_wdata = buf_rdata;
  assign sts.done  = busy_r && !rd_act_r && !wr_v_r;
  assign sts.wrote = wrote_r;

  always_comb begin
    busy_nxt   = busy_r;
    rd_act_nxt = rd_act_r;
    k_nxt      = k_r;
    wr_v_nxt   = 1'b0;
    wr_idx_nxt = wr_idx_r;
    wrote_nxt  = wrote_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      rd_act_nxt = req.nwords != '0;
      k_nxt      = '0;
      wrote_nxt  = '0;
    end else begin
      if (rd_act_r) begin
        // The word read now is written in the next cycle, when the RAM data arrives.
        wr_v_nxt   = 1'b1;
        wr_idx_nxt = pvr_pkg::IDX_W'({2'b00, req.base}) + pvr_pkg::IDX_W'(k_r);
        k_nxt      = k_r + pvr_pkg::NW_W'(1);
        if (k_r == req.nwords - pvr_pkg::NW_W'(1)) begin
          rd_act_nxt = 1'b0;
        end
      end
      if (arr_we) begin
        wrote_nxt = wrote_r + 11'd1;
      end
      if (req.ack) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_act_r <= 1'b0;
      wr_v_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      rd_act_r <= rd_act_nxt;
      wr_v_r   <= wr_v_nxt;
    end
    k_r      <= k_nxt;
    wr_idx_r <= wr_idx_nxt;
    wrote_r  <= wrote_nxt;
  end

`ifndef SYNTH
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> $past(rd_act_r))
    else $error("copy write without a preceding buffer read");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> !buf_re && !arr_we)
    else $error("copy reports done while still moving words");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !arr_we)
    else $error("array write while copy idle");
`endif

endmodule

>>> hdl/packet_verify_reassemble.sv
// Top level: byte parser, checksum check, payload buffer and array store.
//
//  channel | ports                         | direction | transaction
//  in      | in_valid, in_ready, in_data   | input     | one packet byte or one read request
//  out     | out_valid, out_ready, out_data| output    | one verdict or one read word
//  cfg     | cfg_valid, cfg_ready, cfg_data| input     | write of the array write cap
//
// A packet byte without last is taken in the idle state. A final byte then passes
// through header summing, modulo folding and the decision; an accepted packet
// then runs a copy pass that moves one word a cycle from the buffer read port to
// the array write port. A read passes through the read state. Reset clears
// control state only; both memories start undefined.
// A waiting result stalls the block only where a new result is to be loaded.
module packet_verify_reassemble (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pvr_pkg::pvr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pvr_pkg::pvr_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [12:0]      cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_H1   = 3'd1;
  localparam logic [2:0] S_H2   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_COPY = 3'd5;
  localparam logic [2:0] S_RD   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [12:0] wr_cap_r;
  logic [7:0]  hdr_r [16];
  logic [13:0] pos_r, pos_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [31:0] rsum_r, rsum_nxt;
  logic [31:0] parta_r, parta_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [23:0] fold_r, fold_nxt;
  logic        rd_oor_r, rd_oor_nxt;
  logic [31:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;
  pvr_pkg::pvr_out_t out_r, out_nxt;

  logic        acc, out_free;
  logic [13:0] p;
  logic [31:0] word;
  logic [11:0] wi;
  logic        buf_we;

  logic [27:0] src, dst;
  logic [13:0] frag, len, lenm;
  logic [4:0]  hop;
  logic [22:0] recv, comp;
  logic [11:0] nw_full;
  logic        malformed;
  logic [12:0] limit;

  pvr_pkg::pvr_copy_req_t creq;
  pvr_pkg::pvr_copy_sts_t csts;
  logic                       cbuf_re;
  logic [pvr_pkg::PB_AW-1:0]  cbuf_raddr;
  logic [31:0]                buf_q;
  logic                       arr_we;
  logic [pvr_pkg::AR_AW-1:0]  arr_waddr;
  logic [31:0]                arr_wdata, arr_q;
  logic                       arr_re;

  assign in_ready  = state_r == S_IDLE;
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign p    = pos_r - pvr_pkg::HEADER_BYTES;
  assign word = {asm_r, in_data.data_byte};
  assign wi   = p[13:2];
  assign buf_we = acc && !in_data.func && (pos_r >= pvr_pkg::HEADER_BYTES) &&
                  (p[1:0] == 2'd3) && ({1'b0, wi} < 13'(pvr_pkg::PAYLOAD_WORDS));
  assign arr_re = acc && in_data.func;

  // Header fields.
  assign src  = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3][7:4]};
  assign dst  = {hdr_r[3][3:0], hdr_r[4], hdr_r[5], hdr_r[6]};
  assign frag = {hdr_r[8], hdr_r[9][7:2]};
  assign len  = {hdr_r[9][1:0], hdr_r[10], hdr_r[11][7:4]};
  assign hop  = {hdr_r[11][3:0], hdr_r[12][7]};
  assign recv = {hdr_r[12][6:0], hdr_r[13], hdr_r[14]};
  assign lenm = len - pvr_pkg::HEADER_BYTES;
  assign nw_full = lenm[13:2];
  assign malformed = (pos_r != len) || (len < pvr_pkg::HEADER_BYTES) || (lenm[1:0] != 2'd0);
  assign comp = (fold_r >= {1'b0, pvr_pkg::CSUM_MOD}) ?
                23'(fold_r - {1'b0, pvr_pkg::CSUM_MOD}) : fold_r[22:0];
  assign limit = (wr_cap_r < 13'(pvr_pkg::ARRAY_WORDS)) ?
                 wr_cap_r : 13'(pvr_pkg::ARRAY_WORDS);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    asm_nxt       = asm_r;
    rsum_nxt      = rsum_r;
    parta_nxt     = parta_r;
    sum_nxt       = sum_r;
    fold_nxt      = fold_r;
    rd_oor_nxt    = rd_oor_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    creq.start    = 1'b0;
    creq.ack      = 1'b0;
    creq.nwords   = pvr_pkg::NW_W'(nw_full);
    creq.base     = frag[13:2];
    creq.limit    = limit;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_data.func) begin
          rd_oor_nxt = {1'b0, in_data.read_index} >= 13'(pvr_pkg::ARRAY_WORDS);
          state_nxt  = S_RD;
        end else if (acc) begin
          if (pos_r >= pvr_pkg::HEADER_BYTES) begin
            if (p[1:0] != 2'd3) begin
              asm_nxt = {asm_r[15:0], in_data.data_byte};
            end else begin
              rsum_nxt = rsum_r + pvr_pkg::abs_wrap(word);
              asm_nxt  = '0;
            end
          end
          if (pos_r != pvr_pkg::POS_MAX) begin
            pos_nxt = pos_r + 14'd1;
          end
          if (in_data.last) begin
            state_nxt = S_H1;
          end
        end
      end
      S_H1: begin
        parta_nxt = 32'(src) + 32'(dst) + 32'(hdr_r[7][7:4]) + 32'(hdr_r[7][3:0]);
        state_nxt = S_H2;
      end
      S_H2: begin
        sum_nxt = rsum_r + parta_r + 32'(frag) + 32'(len) + 32'(hop) +
                  32'(hdr_r[15][7:6]) + 32'(hdr_r[15][5:0]);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // 2^23 is 1 modulo 2^23-1, so the high bits fold onto the low bits.
        fold_nxt  = 24'(sum_r[31:23]) + 24'(sum_r[22:0]);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        out_nxt.result_kind       = pvr_pkg::KIND_VERDICT;
        out_nxt.computed_checksum = comp;
        out_nxt.received_checksum = recv;
        out_nxt.words_written     = '0;
        out_nxt.total_count       = total_r;
        out_nxt.read_data         = '0;
        if (malformed) begin
          out_nxt.packet_status     = pvr_pkg::ST_BAD_LEN;
          out_nxt.computed_checksum = '0;
          out_nxt.received_checksum = '0;
        end else if ({1'b0, nw_full} > 13'(pvr_pkg::PAYLOAD_WORDS)) begin
          out_nxt.packet_status = pvr_pkg::ST_TOO_LONG;
        end else if (comp != recv) begin
          out_nxt.packet_status = pvr_pkg::ST_CSUM_BAD;
        end else begin
          out_nxt.packet_status = pvr_pkg::ST_OK;
        end
        if (!malformed && ({1'b0, nw_full} <= 13'(pvr_pkg::PAYLOAD_WORDS)) &&
            (comp == recv)) begin
          // The output register may still hold an unaccepted transaction; the
          // verdict is loaded when the copy pass ends.
          creq.start = 1'b1;
          out_nxt    = out_r;
          pos_nxt   = '0;
          asm_nxt   = '0;
          rsum_nxt  = '0;
          state_nxt = S_COPY;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = '0;
          asm_nxt       = '0;
          rsum_nxt      = '0;
          state_nxt     = S_IDLE;
        end else begin
          out_nxt = out_r;
        end
      end
      S_COPY: begin
        if (csts.done && out_free) begin
          creq.ack                  = 1'b1;
          total_nxt                 = total_r + 32'(csts.wrote);
          out_nxt.result_kind       = pvr_pkg::KIND_VERDICT;
          out_nxt.packet_status     = pvr_pkg::ST_OK;
          out_nxt.computed_checksum = comp;
          out_nxt.received_checksum = recv;
          out_nxt.words_written     = csts.wrote;
          out_nxt.total_count       = total_r + 32'(csts.wrote);
          out_nxt.read_data         = '0;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      S_RD: begin
        if (out_free) begin
          out_nxt.result_kind       = pvr_pkg::KIND_READ;
          out_nxt.packet_status     = pvr_pkg::ST_OK;
          out_nxt.computed_checksum = '0;
          out_nxt.received_checksum = '0;
          out_nxt.words_written     = '0;
          out_nxt.total_count       = '0;
          out_nxt.read_data         = rd_oor_r ? 32'sd0 : $signed(arr_q);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_cap_r    <= '0;
      pos_r       <= '0;
      asm_r       <= '0;
      rsum_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      asm_r       <= asm_nxt;
      rsum_r      <= rsum_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        wr_cap_r <= cfg_data;
      end
    end
    parta_r  <= parta_nxt;
    sum_r    <= sum_nxt;
    fold_r   <= fold_nxt;
    rd_oor_r <= rd_oor_nxt;
    out_r    <= out_nxt;
    if (acc && !in_data.func && (pos_r < pvr_pkg::HEADER_BYTES)) begin
      hdr_r[pos_r[3:0]] <= in_data.data_byte;
    end
  end

  pvr_ram #(.W(32), .D(pvr_pkg::PAYLOAD_WORDS)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (wi[pvr_pkg::PB_AW-1:0]),
    .wdata (word),
    .re    (cbuf_re),
    .raddr (cbuf_raddr),
    .rdata (buf_q)
  );

  pvr_ram #(.W(32), .D(pvr_pkg::ARRAY_WORDS)) u_arr (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (arr_wdata),
    .re    (arr_re),
    .raddr (in_data.read_index[pvr_pkg::AR_AW-1:0]),
    .rdata (arr_q)
  );

  pvr_copy u_copy (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (creq),
    .sts       (csts),
    .buf_re    (cbuf_re),
    .buf_raddr (cbuf_raddr),
    .buf_rdata (buf_q),
    .arr_we    (arr_we),
    .arr_waddr (arr_waddr),
    .arr_wdata (arr_wdata)
  );

`ifndef SYNTH
  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.func) |=> state_r == S_RD)
    else $error("read transaction did not enter the read state");
  a_arr_write_copy: assert property (@(posedge clk) disable iff (!rst_n)
    arr_we |-> state_r == S_COPY)
    else $error("array write outside the copy pass");
  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_kind == pvr_pkg::KIND_VERDICT &&
     out_data.packet_status != pvr_pkg::ST_OK) |-> out_data.words_written == 11'd0)
    else $error("rejected packet reports written words");
  a_buf_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cbuf_re |-> !buf_we)
    else $error("payload buffer read and written in the same cycle");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for packet_verify_reassemble: directed table, random packets and reads.
`timescale 1ns / 100ps

module tb_top;

  localparam logic PKT_CMD  = 1'b0;
  localparam logic READ_CMD = 1'b1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pvr_pkg::pvr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pvr_pkg::pvr_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [12:0] cfg_data = '0;

  packet_verify_reassemble i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state.
  logic [12:0] len_reg;
  logic [7:0]  hdr [16];
  logic [13:0] pos;
  logic [23:0] asm_word;
  logic [31:0] sum_acc;
  logic [31:0] pbuf [pvr_pkg::PAYLOAD_WORDS];
  logic [31:0] arr [pvr_pkg::ARRAY_WORDS];
  bit          arr_known [pvr_pkg::ARRAY_WORDS];
  logic [31:0] total_written;

  pvr_pkg::pvr_out_t verdict_q[$];
  int       errors = 0;
  bit       long_hold = 0;

  function automatic pvr_pkg::pvr_out_t finish_packet();
    pvr_pkg::pvr_out_t r;
    logic [31:0] plen, nw, src, dst, frag, hop, s, comp, recv, lim, idx, wrote;
    r = '0;
    plen = {18'd0, hdr[9][1:0], hdr[10], hdr[11][7:4]};
    comp = 0; recv = 0; wrote = 0;
    if (pos != plen[13:0] || plen < 16 || plen[1:0] != 2'd0) begin
      r.packet_status = pvr_pkg::ST_BAD_LEN;
    end else begin
      nw = (plen - 16) >> 2;
      src = {4'd0, hdr[0], hdr[1], hdr[2], hdr[3][7:4]};
      dst = {4'd0, hdr[3][3:0], hdr[4], hdr[5], hdr[6]};
      frag = {18'd0, hdr[8], hdr[9][7:2]};
      hop = {27'd0, hdr[11][3:0], hdr[12][7]};
      s = sum_acc + src + dst + hdr[7][7:4] + hdr[7][3:0] + frag + plen + hop
          + hdr[15][7:6] + hdr[15][5:0];
      comp = s % 32'h7FFFFF;
      recv = {9'd0, hdr[12][6:0], hdr[13], hdr[14]};
      if (nw > pvr_pkg::PAYLOAD_WORDS) r.packet_status = pvr_pkg::ST_TOO_LONG;
      else if (comp != recv) r.packet_status = pvr_pkg::ST_CSUM_BAD;
      else begin
        r.packet_status = pvr_pkg::ST_OK;
        lim = (len_reg < pvr_pkg::ARRAY_WORDS) ? len_reg : pvr_pkg::ARRAY_WORDS;
        for (int k = 0; k < nw; k++) begin
          idx = (frag >> 2) + k;
          if (idx < lim) begin
            arr[idx] = pbuf[k];
            arr_known[idx] = 1;
            wrote++;
          end
        end
        total_written += wrote;
      end
    end
    r.result_kind = pvr_pkg::KIND_VERDICT;
    r.computed_checksum = comp[22:0];
    r.received_checksum = recv[22:0];
    r.words_written = wrote[10:0];
    r.total_count = total_written;
    pos = 0; asm_word = 0; sum_acc = 0;
    return r;
  endfunction

  // Advances the predictor by one item; returns 1 and the result if one is due.
  function automatic bit predict_item(input pvr_pkg::pvr_in_t it,
                                      output pvr_pkg::pvr_out_t r);
    logic [13:0] p;
    logic [31:0] w;
    r = '0;
    if (it.func == READ_CMD) begin
      r.result_kind = pvr_pkg::KIND_READ;
      r.read_data = arr[it.read_index];
      return 1;
    end
    if (pos < 16) hdr[pos[3:0]] = it.data_byte;
    else begin
      p = pos - 16;
      if (p[1:0] != 2'd3) asm_word = {asm_word[15:0], it.data_byte};
      else begin
        w = {asm_word, it.data_byte};
        if ((p >> 2) < pvr_pkg::PAYLOAD_WORDS) pbuf[p >> 2] = w;
        sum_acc += w[31] ? (32'd0 - w) : w;
        asm_word = 0;
      end
    end
    if (pos < 14'd16383) pos++;
    if (it.last) begin
      r = finish_packet();
      return 1;
    end
    return 0;
  endfunction

  // A gap drops valid first, so a new item never lands in the same step as a drop.
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input pvr_pkg::pvr_in_t it, input bit has_want,
                           input pvr_pkg::pvr_out_t want);
    pvr_pkg::pvr_out_t r;
    random_gap();
    in_valid <= 1'b1;
    in_data  <= it;
    // Ready is looked at between edges, where it holds the value of the next edge.
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (predict_item(it, r)) begin
      if (has_want && r != want) begin
        $error("directed row disagrees with predictor");
        errors++;
      end
      verdict_q.push_back(r);
    end
  endtask

  task automatic write_len(input logic [12:0] v);
    stop_input();
    while (verdict_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    len_reg = v;
  endtask

  // Builds a packet; mode selects good checksum, bad checksum or bad length.
  task automatic send_packet(input int nwords, input logic [13:0] frag_off,
                             input int mode);
    logic [7:0] b [];
    logic [31:0] s, t, plen, w;
    int n;
    plen = 16 + 4 * nwords;
    n = int'(plen);
    if (mode == 2) n = (plen > 20) ? n - $urandom_range(1, 3) : n + 1;
    b = new[n];
    foreach (b[i]) b[i] = 8'($urandom);
    b[8] = frag_off[13:6];
    b[9] = {frag_off[5:0], plen[13:12]};
    b[10] = plen[11:4];
    b[11][7:4] = plen[3:0];
    // Checksum computed without the recv field, then patched in.
    s = 0;
    for (int k = 0; k < nwords && 16 + 4 * k + 3 < n; k++) begin
      w = {b[16+4*k], b[17+4*k], b[18+4*k], b[19+4*k]};
      s += w[31] ? (32'd0 - w) : w;
    end
    s += {b[0], b[1], b[2], b[3][7:4]} + {b[3][3:0], b[4], b[5], b[6]}
         + b[7][7:4] + b[7][3:0] + {b[8], b[9][7:2]} + plen
         + {b[11][3:0], b[12][7]} + b[15][7:6] + b[15][5:0];
    t = s % 32'h7FFFFF;
    if (mode == 1) t = (t + 1) % 32'h7FFFFF;
    b[12][6:0] = t[22:16];
    b[13] = t[15:8];
    b[14] = t[7:0];
    for (int i = 0; i < n; i++) begin
      pvr_pkg::pvr_in_t it;
      it.func = PKT_CMD;
      it.data_byte = b[i];
      it.last = (i == n - 1);
      it.read_index = 12'($urandom);
      send_item(it, 0, '0);
    end
  endtask

  task automatic send_read();
    pvr_pkg::pvr_in_t it;
    int idx;
    idx = -1;
    for (int tries = 0; tries < 20 && idx < 0; tries++) begin
      int c;
      c = $urandom_range(0, 4095);
      if (arr_known[c]) idx = c;
    end
    if (idx < 0) return;
    it = {READ_CMD, 8'($urandom), 1'($urandom), 12'(idx)};
    send_item(it, 0, '0);
  endtask

  // Receiver: random stalls plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result kind=%0d", out_data.result_kind);
        errors++;
      end else begin
        pvr_pkg::pvr_out_t e;
        e = verdict_q.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0h got %0h", e.result_kind, out_data.result_kind); errors++;
        end
        if (out_data.packet_status !== e.packet_status) begin
          $error("packet_status exp %0h got %0h", e.packet_status, out_data.packet_status);
          errors++;
        end
        if (out_data.computed_checksum !== e.computed_checksum) begin
          $error("computed_checksum exp %0h got %0h", e.computed_checksum,
                 out_data.computed_checksum); errors++;
        end
        if (out_data.received_checksum !== e.received_checksum) begin
          $error("received_checksum exp %0h got %0h", e.received_checksum,
                 out_data.received_checksum); errors++;
        end
        if (out_data.words_written !== e.words_written) begin
          $error("words_written exp %0h got %0h", e.words_written, out_data.words_written);
          errors++;
        end
        if (out_data.total_count !== e.total_count) begin
          $error("total_count exp %0h got %0h", e.total_count, out_data.total_count); errors++;
        end
        if (out_data.read_data !== e.read_data) begin
          $error("read_data exp %0h got %0h", e.read_data, out_data.read_data); errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  typedef struct {
    pvr_pkg::pvr_in_t  item;
    bit                has_want;
    pvr_pkg::pvr_out_t want;
  } row_t;

  initial begin
    row_t rows[$];
    pos = 0; asm_word = 0; sum_acc = 0; total_written = 0; len_reg = 0;
    foreach (arr_known[i]) arr_known[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 16-byte packet of zeros is malformed, then a lone final byte too.
    for (int i = 0; i < 16; i++)
      rows.push_back('{'{PKT_CMD, 8'h00, i == 15, 12'h000}, i == 15,
                       '{pvr_pkg::KIND_VERDICT, pvr_pkg::ST_BAD_LEN, '0, '0, '0, '0, '0}});
    rows.push_back('{'{PKT_CMD, 8'hFF, 1'b1, 12'hFFF}, 1,
                     '{pvr_pkg::KIND_VERDICT, pvr_pkg::ST_BAD_LEN, '0, '0, '0, '0, '0}});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_want, rows[i].want);

    write_len(13'd0);
    send_packet(2, 14'd0, 0);
    write_len(13'h1FFF);
    send_packet(1, 14'd0, 0);
    send_packet(4, 14'h3FFF, 0);
    send_packet(3, 14'd8, 1);
    send_packet(3, 14'd8, 2);
    send_packet(0, 14'd16, 0);
    send_read();

    for (int phase = 0; phase < 4; phase++) begin
      write_len(phase == 0 ? 13'd4096 : phase == 1 ? 13'd64 : phase == 2 ? 13'd4095
                : 13'($urandom_range(1, 4096)));
      if (phase == 1) long_hold = 1;
      for (int j = 0; j < 17; j++) begin
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) send_packet($urandom_range(0, 6), 14'($urandom_range(0, 16383)), 0);
        else if (r == 6) send_packet($urandom_range(0, 4), 14'($urandom), 1);
        else if (r == 7) send_packet($urandom_range(0, 4), 14'($urandom), 2);
        else repeat (3) send_read();
      end
      // Sender pause until everything has drained.
      stop_input();
      while (verdict_q.size() != 0) @(posedge clk);
    end

    stop_input();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
